// ----- sv/assert_macros.svh -----
// Assertion macros shared by the Playfair stream RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- sv/pfc_pkg.sv -----
// Package for the Playfair digram cipher stream: types, constants and the
// key square lookup and substitution functions. Depends on nothing.
package pfc_pkg;

    localparam int SQ        = 5;
    localparam int NUM_CELLS = SQ * SQ;
    localparam int LETTER_W  = 5;
    localparam int POS_W     = 3;
    localparam int ASCII_W   = 7;
    localparam int CHAR_W    = 8;

    localparam int CELLS_PER_WORD = 12;
    localparam int CFG_DATA_W     = CELLS_PER_WORD * LETTER_W;
    localparam int CFG_INDEX_W    = 2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_DECRYPT_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CELLS_LOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CELLS_MID    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_LAST    = 2'd3;

    localparam logic [LETTER_W-1:0] LETTER_I   = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J   = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_X   = 5'd23;
    localparam logic [LETTER_W-1:0] LETTER_MAX = 5'd25;

    localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0]  CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0]  CHAR_LOWER_Z = 8'h7A;
    localparam logic [ASCII_W-1:0] ASCII_A      = 7'h41;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [NUM_CELLS-1:0][LETTER_W-1:0] square_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } pos_t;

    typedef struct packed {
        logic    err;
        letter_t a;
        letter_t b;
    } digram_t;

    // One accepted word's digrams, in output order.
    typedef struct packed {
        logic    valid;
        logic    two;
        digram_t d0;
        digram_t d1;
    } pair_rec_t;

    typedef struct packed {
        logic [ASCII_W-1:0] first_letter;
        logic [ASCII_W-1:0] second_letter;
        logic               status;
        logic               last_of_run;
    } result_t;

    typedef struct packed {
        logic    valid;
        logic    two;
        result_t r0;
        result_t r1;
    } subst_rec_t;

    // First cell in row-major order that holds the letter; row 0, col 0 if none.
    function automatic pos_t locate(square_t sq, letter_t l);
        logic [NUM_CELLS-1:0] hit;
        logic [NUM_CELLS-1:0] first;
        pos_t                 p;
        for (int k = 0; k < NUM_CELLS; k++) begin
            hit[k] = (sq[k] == l);
        end
        first = hit & (~hit + 1'b1);
        p = '0;
        for (int k = 0; k < NUM_CELLS; k++) begin
            p.row = p.row | ({POS_W{first[k]}} & POS_W'(k / SQ));
            p.col = p.col | ({POS_W{first[k]}} & POS_W'(k % SQ));
        end
        return p;
    endfunction

    function automatic logic [POS_W-1:0] shift_pos(logic [POS_W-1:0] v, logic dec);
        logic [POS_W-1:0] r;
        if (dec) begin
            r = (v == '0) ? POS_W'(SQ - 1) : v - 1'b1;
        end else begin
            r = (v == POS_W'(SQ - 1)) ? '0 : v + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [ASCII_W-1:0] cell_ascii(square_t sq, logic [POS_W-1:0] row,
                                                      logic [POS_W-1:0] col);
        logic [LETTER_W-1:0] idx;
        letter_t             v;
        idx = LETTER_W'(row) * LETTER_W'(SQ) + LETTER_W'(col);
        v   = sq[idx];
        if (v > LETTER_MAX) begin
            v = LETTER_MAX;
        end
        return ASCII_A + ASCII_W'(v);
    endfunction

    function automatic result_t substitute(square_t sq, digram_t d, logic dec);
        pos_t    p1;
        pos_t    p2;
        result_t r;
        p1 = locate(sq, d.a);
        p2 = locate(sq, d.b);
        r  = '0;
        if (d.err) begin
            r.status = 1'b1;
        end else if (p1.row == p2.row) begin
            r.first_letter  = cell_ascii(sq, p1.row, shift_pos(p1.col, dec));
            r.second_letter = cell_ascii(sq, p2.row, shift_pos(p2.col, dec));
        end else if (p1.col == p2.col) begin
            r.first_letter  = cell_ascii(sq, shift_pos(p1.row, dec), p1.col);
            r.second_letter = cell_ascii(sq, shift_pos(p2.row, dec), p2.col);
        end else begin
            r.first_letter  = cell_ascii(sq, p1.row, p2.col);
            r.second_letter = cell_ascii(sq, p2.row, p1.col);
        end
        return r;
    endfunction

endpackage

// ----- sv/pfc_stream_if.sv -----
// Valid/ready channel interfaces for text bytes in and digrams out.
// Depends on pfc_pkg for field widths.
interface pfc_in_if import pfc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              end_of_text;

    modport source (output valid, output char_in, output end_of_text, input ready);
    modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

interface pfc_out_if import pfc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ASCII_W-1:0] first_letter;
    logic [ASCII_W-1:0] second_letter;
    logic               status;
    logic               last_of_run;

    modport source (output valid, output first_letter, output second_letter,
                    output status, output last_of_run, input ready);
    modport sink   (input valid, input first_letter, input second_letter,
                    input status, input last_of_run, output ready);
endinterface

// ----- sv/pfc_pair.sv -----
// Letter filter, digram pairing with the held letter, and the pair register.
// Depends on pfc_pkg, pfc_stream_if and assert_macros.svh.
`include "assert_macros.svh"

module pfc_pair import pfc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    pfc_in_if.sink    in_ch,
    input  logic      decrypt_mode,
    input  logic      space,
    output pair_rec_t rec
);

    pair_rec_t rec_reg;
    pair_rec_t rec_next;
    letter_t   pending_letter_reg;
    letter_t   pending_letter_next;
    logic      pending_valid_reg;
    logic      pending_valid_next;

    logic      accept;
    logic      is_letter;
    letter_t   letter;
    logic      hold_valid;
    letter_t   hold_letter;
    logic      e0;
    logic      e1;
    digram_t   dl;
    digram_t   de;

    assign in_ch.ready = !rec_reg.valid || space;
    assign accept      = in_ch.valid && in_ch.ready;
    assign rec         = rec_reg;

    always_comb
    begin
        is_letter = 1'b0;
        letter    = '0;
        if (in_ch.char_in inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            is_letter = 1'b1;
            letter    = LETTER_W'(in_ch.char_in - CHAR_UPPER_A);
        end else if (in_ch.char_in inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            is_letter = 1'b1;
            letter    = LETTER_W'(in_ch.char_in - CHAR_LOWER_A);
        end
        if (letter == LETTER_J) begin
            letter = LETTER_I;
        end

        // letter against the held letter
        e0          = 1'b0;
        dl.err      = 1'b0;
        dl.a        = pending_letter_reg;
        dl.b        = letter;
        hold_valid  = pending_valid_reg;
        hold_letter = pending_letter_reg;
        if (is_letter) begin
            if (!pending_valid_reg) begin
                hold_valid  = 1'b1;
                hold_letter = letter;
            end else if (!decrypt_mode && pending_letter_reg == letter) begin
                e0          = 1'b1;
                dl.b        = LETTER_X;
                hold_letter = letter;
            end else begin
                e0          = 1'b1;
                hold_valid  = 1'b0;
                hold_letter = '0;
            end
        end

        // end of text flushes whatever is still held
        e1     = in_ch.end_of_text && hold_valid;
        de.err = decrypt_mode;
        de.a   = decrypt_mode ? '0 : hold_letter;
        de.b   = decrypt_mode ? '0 : LETTER_X;

        if (in_ch.end_of_text) begin
            pending_valid_next  = 1'b0;
            pending_letter_next = '0;
        end else begin
            pending_valid_next  = hold_valid;
            pending_letter_next = hold_letter;
        end

        rec_next = rec_reg;
        if (accept) begin
            rec_next.valid = e0 || e1;
            rec_next.two   = e0 && e1;
            rec_next.d0    = e0 ? dl : de;
            rec_next.d1    = de;
        end else if (space) begin
            rec_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rec_reg            <= '0;
            pending_letter_reg <= '0;
            pending_valid_reg  <= 1'b0;
        end else begin
            rec_reg <= rec_next;
            if (accept) begin
                pending_letter_reg <= pending_letter_next;
                pending_valid_reg  <= pending_valid_next;
            end
        end
    end

    `ASSERT_CLKD(a_end_clears_hold, clk, rst_n, accept && in_ch.end_of_text |=> !pending_valid_reg, "held letter survived end of text")
    `ASSERT_CLKD(a_err_only_last, clk, rst_n, rec_reg.valid && rec_reg.two |-> !rec_reg.d0.err, "error digram placed before another digram")

endmodule

// ----- sv/pfc_subst.sv -----
// Key square lookup and row, column or rectangle substitution of two digrams.
// Depends on pfc_pkg.
module pfc_subst import pfc_pkg::*; (
    input  pair_rec_t  rec,
    input  square_t    square,
    input  logic       decrypt_mode,
    output subst_rec_t res
);

    always_comb
    begin
        res.valid          = rec.valid;
        res.two            = rec.two;
        res.r0             = substitute(square, rec.d0, decrypt_mode);
        res.r1             = substitute(square, rec.d1, decrypt_mode);
        res.r0.last_of_run = !rec.two;
        res.r1.last_of_run = 1'b1;
    end

endmodule

// ----- sv/pfc_outq.sv -----
// Result queue: one or two digrams in per cycle with two slots free, one out per cycle with sink ready.
// Depends on pfc_pkg, pfc_stream_if and assert_macros.svh.
`include "assert_macros.svh"

module pfc_outq import pfc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  subst_rec_t res,
    output logic       space,
    pfc_out_if.source  out_ch
);

    result_t           q_reg [QDEPTH];
    logic [QPTR_W-1:0] head_reg;
    logic [QPTR_W-1:0] head_next;
    logic [QPTR_W-1:0] tail_reg;
    logic [QPTR_W-1:0] tail_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic [1:0]        push_cnt;
    logic              pop;
    logic [QPTR_W-1:0] tail_plus1;

    // room for two words regardless of the output side
    assign space      = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign push       = res.valid && space;
    assign push_cnt   = push ? (res.two ? 2'd2 : 2'd1) : 2'd0;
    assign pop        = out_ch.valid && out_ch.ready;
    assign tail_plus1 = tail_reg + 1'b1;

    assign out_ch.valid         = (count_reg != '0);
    assign out_ch.first_letter  = q_reg[head_reg].first_letter;
    assign out_ch.second_letter = q_reg[head_reg].second_letter;
    assign out_ch.status        = q_reg[head_reg].status;
    assign out_ch.last_of_run   = q_reg[head_reg].last_of_run;

    always_comb
    begin
        head_next  = head_reg + QPTR_W'(pop);
        tail_next  = tail_reg + QPTR_W'(push_cnt);
        count_next = count_reg + QCNT_W'(push_cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            q_reg[tail_reg] <= res.r0;
            if (res.two) begin
                q_reg[tail_plus1] <= res.r1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > QCNT_W'(QDEPTH), "queue count above depth")
    `ASSERT_CLKD(a_count_track, clk, rst_n, 1'b1 |=> count_reg == $past(count_reg) + QCNT_W'($past(push_cnt)) - QCNT_W'($past(pop)), "queue count lost track")
    `ASSERT_CLKD(a_ptr_span, clk, rst_n, count_reg[QPTR_W-1:0] == QPTR_W'(tail_reg - head_reg), "queue pointers disagree with count")

endmodule

// ----- sv/playfair_digram_cipher_stream.sv -----
// Playfair digram cipher stream, top level: configuration registers and the
// pair, substitution and result queue stages. Depends on pfc_pkg,
// pfc_stream_if, pfc_pair, pfc_subst and pfc_outq.
// A byte accepted is registered in the pair register, then its digrams go into the
// result queue. Throughput: one text byte per cycle while the pair register is free
// or the queue has two free slots; one digram leaves per cycle, so once the queue
// holds a backlog a byte that closes two digrams can stall the input.
// Reset: clears the held letter, the queue, the mode and all key square cells.
module playfair_digram_cipher_stream import pfc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    pfc_in_if.sink                 in_ch,
    pfc_out_if.source              out_ch
);

    // Key square, row-major, one letter index per cell; mode bit beside it.
    square_t    square_reg;
    logic       decrypt_mode_reg;

    pair_rec_t  pair_rec;
    subst_rec_t subst_rec;
    logic       space;

    // Configuration writes must arrive only while the stream is idle; the block does not
    // enforce this, and the cells and mode are used directly by the datapath without shadowing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            square_reg       <= '0;
            decrypt_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DECRYPT_MODE: decrypt_mode_reg <= cfg_data[0];
                REG_CELLS_LOW:
                begin
                    for (int k = 0; k < CELLS_PER_WORD; k++) begin
                        square_reg[k] <= cfg_data[k*LETTER_W +: LETTER_W];
                    end
                end
                REG_CELLS_MID:
                begin
                    for (int k = 0; k < CELLS_PER_WORD; k++) begin
                        square_reg[CELLS_PER_WORD + k] <= cfg_data[k*LETTER_W +: LETTER_W];
                    end
                end
                REG_CELL_LAST: square_reg[NUM_CELLS-1] <= cfg_data[LETTER_W-1:0];
                default: ;
            endcase
        end
    end

    // Filter and fold the byte, pair it with the held letter, register digrams.
    pfc_pair u_pair (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .decrypt_mode (decrypt_mode_reg),
        .space        (space),
        .rec          (pair_rec)
    );

    // Locate both letters of each digram and apply the square rules.
    pfc_subst u_subst (
        .rec          (pair_rec),
        .square       (square_reg),
        .decrypt_mode (decrypt_mode_reg),
        .res          (subst_rec)
    );

    // Hold results until the sink takes them; advance a full pair stage only
    // when two free slots are guaranteed.
    pfc_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .res    (subst_rec),
        .space  (space),
        .out_ch (out_ch)
    );

endmodule
